/* hw/rtl/dcq_pkg.sv */
// Shared types, constants and codes for the dual circular queue block.
// No dependencies; imported by every module of the block except dcq_ram.
package dcq_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int DATA_WIDTH  = 32;

	localparam int STORE_DEPTH = 2 * QUEUE_DEPTH;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int OPQ_DEPTH   = 2;
	localparam int OPQ_IDX_W   = $clog2(OPQ_DEPTH);
	localparam int OPQ_CNT_W   = $clog2(OPQ_DEPTH + 1);

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	localparam logic QSEL_FIRST  = 1'b0;
	localparam logic QSEL_SECOND = 1'b1;

	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic               command;
		logic               queue_select;
		logic signed [31:0] push_value;
	} dcq_in_t;

	typedef struct packed {
		logic signed [31:0] pop_value;
		logic [1:0]         status;
		logic               first_empty;
		logic               first_full;
		logic               second_empty;
		logic               second_full;
	} dcq_out_t;

	typedef struct packed {
		logic first_empty;
		logic first_full;
		logic second_empty;
		logic second_full;
	} dcq_flags_t;

	// Classified operation handed from front to back
	typedef struct packed {
		logic                  wr;
		logic                  rd;
		logic [ADDR_W-1:0]     addr;
		logic [DATA_WIDTH-1:0] wdata;
		logic [1:0]            status;
		dcq_flags_t            flags;
	} dcq_op_t;

endpackage

/* hw/rtl/dcq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dcq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/dcq_front.sv */
// Front end: accepts commands, checks full/empty, owns heads, tails and counts.
// Depends on dcq_pkg.
module dcq_front
	import dcq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dcq_in_t in_item,
	output logic    op_valid,
	input  logic    op_ready,
	output dcq_op_t op
);

	logic [PTR_W-1:0] head_q [2];
	logic [PTR_W-1:0] tail_q [2];
	logic [CNT_W-1:0] count_q [2];

	logic             sel;
	logic             is_push;
	logic             refuse;
	logic             accept;
	logic [CNT_W-1:0] cnt;
	logic [PTR_W-1:0] ptr;
	logic [PTR_W-1:0] ptr_adv;
	logic [CNT_W-1:0] cnt_nxt;
	logic [CNT_W-1:0] first_cnt;
	logic [CNT_W-1:0] second_cnt;

	always_comb begin
		sel     = in_item.queue_select;
		is_push = (in_item.command == CMD_PUSH);
		cnt     = count_q[sel];
		refuse  = is_push ? (cnt == CNT_W'(QUEUE_DEPTH)) : (cnt == '0);
		ptr     = is_push ? tail_q[sel] : head_q[sel];
		ptr_adv = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
		if (refuse) begin
			cnt_nxt = cnt;
		end else if (is_push) begin
			cnt_nxt = cnt + CNT_W'(1);
		end else begin
			cnt_nxt = cnt - CNT_W'(1);
		end
		first_cnt  = (sel == QSEL_FIRST) ? cnt_nxt : count_q[0];
		second_cnt = (sel == QSEL_SECOND) ? cnt_nxt : count_q[1];

		op.wr    = is_push && !refuse;
		op.rd    = !is_push && !refuse;
		op.addr  = (sel == QSEL_SECOND) ? ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr) : ADDR_W'(ptr);
		op.wdata = DATA_WIDTH'(in_item.push_value);
		if (!refuse) begin
			op.status = STATUS_DONE;
		end else if (is_push) begin
			op.status = STATUS_FULL;
		end else begin
			op.status = STATUS_EMPTY;
		end
		op.flags.first_empty  = (first_cnt == '0);
		op.flags.first_full   = (first_cnt == CNT_W'(QUEUE_DEPTH));
		op.flags.second_empty = (second_cnt == '0);
		op.flags.second_full  = (second_cnt == CNT_W'(QUEUE_DEPTH));
	end

	assign in_ready = op_ready;
	assign op_valid = in_valid;
	assign accept   = in_valid && op_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (accept && !refuse) begin
			count_q[sel] <= cnt_nxt;
			if (is_push) begin
				tail_q[sel] <= ptr_adv;
			end else begin
				head_q[sel] <= ptr_adv;
			end
		end
	end

endmodule

/* hw/rtl/dcq_opq.sv */
// Short operation queue decoupling front end from back end.
// Depends on dcq_pkg.
module dcq_opq
	import dcq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_valid,
	output logic    wr_ready,
	input  dcq_op_t wr_op,
	output logic    rd_valid,
	input  logic    rd_ready,
	output dcq_op_t rd_op
);

	dcq_op_t              slot_q [OPQ_DEPTH];
	logic [OPQ_IDX_W-1:0] wptr_q;
	logic [OPQ_IDX_W-1:0] rptr_q;
	logic [OPQ_CNT_W-1:0] cnt_q;
	logic                 push;
	logic                 pop;

	assign wr_ready = (cnt_q != OPQ_CNT_W'(OPQ_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_op    = slot_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == OPQ_IDX_W'(OPQ_DEPTH - 1)) ? '0 : wptr_q + OPQ_IDX_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == OPQ_IDX_W'(OPQ_DEPTH - 1)) ? '0 : rptr_q + OPQ_IDX_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + OPQ_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - OPQ_CNT_W'(1);
			end
		end
	end

endmodule

/* hw/rtl/dcq_back.sv */
// Back end: performs the shared-memory access and drives the result register.
// Depends on dcq_pkg and dcq_ram.
module dcq_back
	import dcq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     op_valid,
	output logic     op_ready,
	input  dcq_op_t  op,
	output logic     out_valid,
	input  logic     out_ready,
	output dcq_out_t out_item
);

	logic                         valid_s1;
	logic                         rd_s1;
	logic [1:0]                   status_s1;
	dcq_flags_t                   flags_s1;
	logic                         out_valid_q;
	dcq_out_t                     out_q;
	logic                         load_out;
	logic                         issue;
	logic [DATA_WIDTH-1:0]        rdata;
	logic signed [DATA_WIDTH-1:0] rdata_s;

	// RAM read data only moves on issue, so it holds while s1 is stalled
	assign load_out = valid_s1 && (!out_valid_q || out_ready);
	assign issue    = op_valid && (!valid_s1 || load_out);
	assign op_ready = !valid_s1 || load_out;
	assign rdata_s  = rdata;

	dcq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (issue && op.wr),
		.waddr(op.addr),
		.wdata(op.wdata),
		.re   (issue && op.rd),
		.raddr(op.addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_s1     <= op.rd;
			status_s1 <= op.status;
			flags_s1  <= op.flags;
		end
		if (load_out) begin
			out_q.pop_value    <= rd_s1 ? 32'(rdata_s) : '0;
			out_q.status       <= status_s1;
			out_q.first_empty  <= flags_s1.first_empty;
			out_q.first_full   <= flags_s1.first_full;
			out_q.second_empty <= flags_s1.second_empty;
			out_q.second_full  <= flags_s1.second_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (load_out) begin
				valid_s1 <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

/* hw/rtl/dual_circular_queue_shared_memory_top.sv */
// Two circular queues sharing one memory, each owning half of it.
// A result passes through the operation queue, the RAM access stage and the result register.
// Throughput: one command per cycle while out_ready stays high; each command makes at most one RAM access.
// Reset (arst_n low, asynchronous): heads, tails, counts and all valid flags clear;
// the shared memory is not cleared, entries are only read after being written.
// Depends on dcq_pkg, dcq_front, dcq_opq, dcq_back (and dcq_ram through dcq_back).
module dual_circular_queue_shared_memory_top
	import dcq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dcq_in_t  in_item,
	output logic     out_valid,
	input  logic     out_ready,
	output dcq_out_t out_item
);

	// Front to queue transfer
	logic    fq_valid;
	logic    fq_ready;
	dcq_op_t fq_op;

	// Queue to back transfer
	logic    qb_valid;
	logic    qb_ready;
	dcq_op_t qb_op;

	// Front end classifies each command and updates the queue pointers at
	// acceptance, so later commands see the new occupancy straight away.
	dcq_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item (in_item),
		.op_valid(fq_valid),
		.op_ready(fq_ready),
		.op      (fq_op)
	);

	// Two-entry queue: memory accesses stay in command order, so a pop
	// always reads after the push that filled its slot.
	dcq_opq u_opq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(fq_valid),
		.wr_ready(fq_ready),
		.wr_op   (fq_op),
		.rd_valid(qb_valid),
		.rd_ready(qb_ready),
		.rd_op   (qb_op)
	);

	// Back end: one RAM access stage, then the result register.
	dcq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (qb_valid),
		.op_ready (qb_ready),
		.op       (qb_op),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

`ifndef SYNTHESIS
	// Refused commands never return data
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status != STATUS_DONE) |-> (out_item.pop_value == '0))
		else $error("refused command returned non-zero data");

	// A queue cannot be empty and full at once
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.first_empty && out_item.first_full) &&
			!(out_item.second_empty && out_item.second_full))
		else $error("queue reported both empty and full");

	// A refused push implies some queue is full afterwards
	a_full_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status == STATUS_FULL) |->
			(out_item.first_full || out_item.second_full))
		else $error("push refused with no full queue");
`endif

endmodule

/* sim/dcq_checker.sv */
// Scoreboard for the dual circular queue: watches both channels, keeps its own
// copy of the two queues and compares every result transfer against it.
// Depends on dcq_pkg for the payload types, sizes and codes.
module dcq_checker
	import dcq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_ready,
	input  dcq_in_t  in_item,
	input  logic     out_valid,
	input  logic     out_ready,
	input  dcq_out_t out_item,
	output int       mismatches,
	output int       pending,
	output int       checked,
	output int       refusals
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PRINTED = 40;

	logic [DATA_WIDTH-1:0] shadow_mem [STORE_DEPTH];
	logic [PTR_W-1:0]      head_idx [2];
	logic [PTR_W-1:0]      tail_idx [2];
	int                    held [2];
	dcq_out_t              awaited_results [$];

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
	endfunction

	// Applies one command to the shadow queues and returns the result it should give
	function automatic dcq_out_t apply_queue_op(input dcq_in_t op);
		dcq_out_t              r;
		int                    q;
		int                    slot;
		logic signed [63:0]    wide;
		logic [DATA_WIDTH-1:0] word;
		q = (op.queue_select == QSEL_SECOND) ? 1 : 0;
		r = '0;
		r.status = STATUS_DONE;
		if (op.command == CMD_PUSH) begin
			if (held[q] >= QUEUE_DEPTH) begin
				r.status = STATUS_FULL;
				refusals++;
			end else begin
				wide = op.push_value;
				slot = q * QUEUE_DEPTH + int'(tail_idx[q]);
				shadow_mem[slot] = wide[DATA_WIDTH-1:0];
				tail_idx[q] = next_slot(tail_idx[q]);
				held[q]++;
			end
		end else begin
			if (held[q] == 0) begin
				r.status = STATUS_EMPTY;
				refusals++;
			end else begin
				slot = q * QUEUE_DEPTH + int'(head_idx[q]);
				word = shadow_mem[slot];
				wide = $signed(word);
				r.pop_value = wide[31:0];
				head_idx[q] = next_slot(head_idx[q]);
				held[q]--;
			end
		end
		r.first_empty  = (held[0] == 0);
		r.first_full   = (held[0] == QUEUE_DEPTH);
		r.second_empty = (held[1] == 0);
		r.second_full  = (held[1] == QUEUE_DEPTH);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < MAX_PRINTED)
			$display("%0t ns dcq_checker: %s got 0x%08h, expected 0x%08h",
				$realtime, what, got, want);
		mismatches++;
	endtask

	task automatic compare_result(input dcq_out_t got, input dcq_out_t want);
		if (got.pop_value !== want.pop_value)
			report_mismatch("pop_value", got.pop_value, want.pop_value);
		if (got.status !== want.status)
			report_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.first_empty !== want.first_empty)
			report_mismatch("first_empty", 32'(got.first_empty), 32'(want.first_empty));
		if (got.first_full !== want.first_full)
			report_mismatch("first_full", 32'(got.first_full), 32'(want.first_full));
		if (got.second_empty !== want.second_empty)
			report_mismatch("second_empty", 32'(got.second_empty), 32'(want.second_empty));
		if (got.second_full !== want.second_full)
			report_mismatch("second_full", 32'(got.second_full), 32'(want.second_full));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_idx[0] = '0;
			head_idx[1] = '0;
			tail_idx[0] = '0;
			tail_idx[1] = '0;
			held[0] = 0;
			held[1] = 0;
			awaited_results.delete();
			mismatches = 0;
			checked = 0;
			refusals = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result with nothing outstanding", out_item.pop_value, '0);
				end else begin
					compare_result(out_item, awaited_results.pop_front());
				end
				checked++;
			end
			if (in_valid && in_ready)
				awaited_results.push_back(apply_queue_op(in_item));
			pending <= awaited_results.size();
		end
	end

endmodule

/* sim/dual_circular_queue_shared_memory_top_tb.sv */
// Testbench top for the dual circular queue: drives commands and result back-pressure,
// and gives the verdict from the mismatch and pending counts of dcq_checker.
// Depends on dcq_pkg, dcq_checker and the block's RTL.
module dual_circular_queue_shared_memory_top_tb;
	import dcq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES = 11;
	localparam int RANDOM_ITEMS = 1200;
	localparam int QUIET_TAIL   = 150;   // last transfers run with no idling at all
	localparam int LONG_HOLD    = 60;    // receiver stall long enough to back up the pipe
	localparam int SETTLE       = 10;    // margin after the drain for any straggler
	localparam int CYCLE_LIMIT  = 200000;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	dcq_in_t  in_item;
	logic     out_valid;
	logic     out_ready;
	dcq_out_t out_item;

	int mismatches;
	int pending;
	int checked;
	int refusals;

	// Shared between the sender and receiver processes
	bit stall_bursts;    // random idles allowed on both sides
	bit hold_request;    // asks the receiver for one long stall
	int directed_sent;
	int random_sent;

	dual_circular_queue_shared_memory_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	dcq_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked),
		.refusals   (refusals)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hang anywhere ends the run as a failure
	initial begin
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[dual_circular_queue_shared_memory_top] ERROR");
		$finish;
	end

	// Result side. Each pass starts on a rising edge, makes exactly one
	// assignment to out_ready and then lets time move on.
	initial begin
		out_ready = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (stall_bursts && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// One command transfer. Returns on the edge at which it was taken, so the
	// next call can keep in_valid high without dropping it in between.
	task automatic send_op(input logic cmd, input logic sel, input logic [31:0] val);
		dcq_in_t op;
		op.command      = cmd;
		op.queue_select = sel;
		op.push_value   = val;
		if (stall_bursts && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= op;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop offering and wait for every outstanding result. pending is registered
	// in the checker, hence the edge before the first look.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 11))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] extremes [8];
		int          seq_len;
		int          push_pct;
		int          sel_mode;
		logic        fixed_sel;
		logic        sel;
		logic        cmd;
		bit          hold_done;
		bit          pause_done;
		bit          pressure_now;

		extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
			32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFE};
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_item      = '0;
		stall_bursts = 1'b0;
		hold_request = 1'b0;
		hold_done    = 1'b0;
		pause_done   = 1'b0;
		directed_sent = 0;
		random_sent   = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pops on empty queues, the first queue filled with extreme
		// values until a push is refused, then the first drained past empty and
		// the second emptied. Pops carry junk in push_value, which must be ignored.
		stall_bursts = 1'b1;
		send_op(CMD_POP, QSEL_FIRST, 32'hDEAD_BEEF);
		send_op(CMD_POP, QSEL_SECOND, 32'hFFFF_FFFF);
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_op(CMD_PUSH, QSEL_FIRST, extremes[i % 8]);
		send_op(CMD_PUSH, QSEL_FIRST, 32'h1234_5678);
		send_op(CMD_PUSH, QSEL_SECOND, 32'h8000_0000);
		send_op(CMD_PUSH, QSEL_SECOND, 32'h7FFF_FFFF);
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_op(CMD_POP, QSEL_FIRST, $urandom);
		send_op(CMD_POP, QSEL_FIRST, 32'h0);
		send_op(CMD_POP, QSEL_SECOND, 32'h0);
		send_op(CMD_POP, QSEL_SECOND, 32'h0);
		directed_sent = 2 * QUEUE_DEPTH + 8;

		// Random: runs of pushes or pops with a bias, so each queue keeps
		// hitting full and empty and its pointers wrap inside their half.
		while (random_sent < RANDOM_ITEMS) begin
			pressure_now = 1'b0;
			if (!hold_done && random_sent >= 300) begin
				// Receiver stalls for a long stretch while we keep sending, mostly pushes
				hold_done    = 1'b1;
				pressure_now = 1'b1;
				hold_request = 1'b1;
			end
			if (!pause_done && random_sent >= 650) begin
				pause_done = 1'b1;
				drain_results();
			end
			seq_len   = $urandom_range(6, 24);
			sel_mode  = $urandom_range(0, 2);
			fixed_sel = logic'($urandom_range(0, 1));
			case ($urandom_range(0, 2))
				0:       push_pct = 85;
				1:       push_pct = 50;
				default: push_pct = 15;
			endcase
			if (pressure_now) begin
				push_pct = 70;
				seq_len  = 30;
				sel_mode = 2;
			end
			stall_bursts = !pressure_now && (random_sent < RANDOM_ITEMS - QUIET_TAIL)
				&& ($urandom_range(0, 2) != 0);
			for (int k = 0; k < seq_len && random_sent < RANDOM_ITEMS; k++) begin
				cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
				sel = (sel_mode == 0) ? fixed_sel : logic'($urandom_range(0, 1));
				send_op(cmd, sel, pick_value());
				random_sent++;
			end
		end

		drain_results();
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d directed and %0d random commands over both queues; %0d results checked.",
			directed_sent, random_sent, checked);
		$display("%0d commands refused on a full or empty queue; %0d mismatches.",
			refusals, mismatches);
		if (mismatches == 0 && pending == 0) begin
			$display("[dual_circular_queue_shared_memory_top] OK");
		end else begin
			$display("[dual_circular_queue_shared_memory_top] ERROR");
		end
		$finish;
	end

endmodule
